### rtl/assert_macros.svh
// Assertion macros used by the RTL of the control packet parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset.
`define CPP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that an expression is never true outside reset.
`define CPP_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CPP_ASSERT(lbl, clk, rstn, prop)
`define CPP_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### rtl/cpp_pkg.sv
// Types, codes and constants of the control packet parser.
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

  localparam logic [7:0] CR_BYTE = 8'd13;

  typedef enum logic [0:0] {
    CFG_SPECIAL_SELECT = 1'b0,
    CFG_FLAG_IS_M      = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BODY  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_SKIP  = 4'b1000
  } parse_state_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_START     = 3'd1,
    EV_BODY      = 3'd2,
    EV_SPECIAL   = 3'd3,
    EV_DISPATCH  = 3'd4,
    EV_DEFERRED  = 3'd5,
    EV_CSUM_ERR  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    CLS_IGNORE      = 2'd0,
    CLS_START       = 2'd1,
    CLS_START_GATED = 2'd2,
    CLS_SKIP        = 2'd3
  } cmd_class_e;

  typedef struct packed {
    parse_state_e st;
    logic [7:0]   idx;
    logic [7:0]   xsum;
    logic [7:0]   code;
    logic [15:0]  started;
    logic [15:0]  defers;
    logic [15:0]  xerrs;
    logic [15:0]  ovfs;
  } cpp_state_t;

  typedef struct packed {
    event_e     evt;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic       length_overflow;
    logic       repaint_request;
  } cpp_res_t;

  function automatic cmd_class_e classify(input logic [7:0] b);
    cmd_class_e c;
    c = CLS_IGNORE;
    case (b) inside
      8'd1, 8'd12, 8'd15:
        c = CLS_START;
      8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd11, 8'd16, 8'd17, 8'd20, 8'd22:
        c = CLS_START_GATED;
      CR_BYTE:
        c = CLS_SKIP;
      default:
        c = CLS_IGNORE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/cpp_step.sv
// Next-state and result logic of the parser for one item.
`timescale 1ns / 1ps
`default_nettype none

module cpp_step #(
  parameter int MAX_INDEX = 198
) (
  input  cpp_pkg::cpp_state_t cur_i,
  input  logic                special_select_i,
  input  logic                flag_is_m_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                line_changed_i,
  input  logic                hold_active_i,
  input  logic                display_active_i,
  input  logic                ui_busy_i,
  input  logic signed [15:0]  defer_countdown_i,
  input  logic                mode_is_zero_i,
  output cpp_pkg::cpp_state_t nxt_o,
  output cpp_pkg::cpp_res_t   res_o
);

  localparam logic [7:0] IdxLimit = 8'(MAX_INDEX);

  logic                bypass;
  logic                go;
  logic                have_len;
  logic [7:0]          len;
  cpp_pkg::cmd_class_e cls;
  cpp_pkg::cpp_state_t nxt;

  assign bypass = special_select_i | flag_is_m_i;
  assign go     = (bypass | (~hold_active_i & ~display_active_i)) & ~ui_busy_i & line_changed_i;

  always_comb begin
    nxt                    = cur_i;
    have_len               = 1'b0;
    len                    = cur_i.idx;
    res_o.evt              = cpp_pkg::EV_NONE;
    res_o.data_byte        = 8'd0;
    res_o.length_overflow  = 1'b0;
    res_o.repaint_request  = 1'b0;
    cls                    = cpp_pkg::classify(rx_byte_i);
    if (go) begin
      case (cur_i.st)
        cpp_pkg::ST_IDLE: begin
          if (cls == cpp_pkg::CLS_START ||
              (cls == cpp_pkg::CLS_START_GATED && !special_select_i)) begin
            nxt.code        = rx_byte_i;
            nxt.xsum        = rx_byte_i;
            nxt.started     = cur_i.started + 16'd1;
            nxt.st          = cpp_pkg::ST_BODY;
            res_o.evt       = cpp_pkg::EV_START;
            res_o.data_byte = rx_byte_i;
          end else if (cls == cpp_pkg::CLS_SKIP) begin
            nxt.st = cpp_pkg::ST_SKIP;
          end
        end
        cpp_pkg::ST_BODY: begin
          nxt.idx = cur_i.idx + 8'd1;
          if (rx_byte_i == cpp_pkg::CR_BYTE) begin
            nxt.st = cpp_pkg::ST_CHECK;
          end
          nxt.xsum        = cur_i.xsum ^ rx_byte_i;
          res_o.evt       = cpp_pkg::EV_BODY;
          res_o.data_byte = rx_byte_i;
        end
        cpp_pkg::ST_CHECK: begin
          if (rx_byte_i != cur_i.xsum) begin
            nxt.xerrs = cur_i.xerrs + 16'd1;
            res_o.evt = cpp_pkg::EV_CSUM_ERR;
          end else if (special_select_i) begin
            res_o.evt             = cpp_pkg::EV_SPECIAL;
            res_o.repaint_request = 1'b1;
            have_len              = 1'b1;
          end else if (defer_countdown_i == 16'sd0 || defer_countdown_i == 16'sd1) begin
            res_o.evt = cpp_pkg::EV_DISPATCH;
            have_len  = 1'b1;
          end else begin
            nxt.defers = cur_i.defers + 16'd1;
            res_o.evt  = cpp_pkg::EV_DEFERRED;
          end
          nxt.st   = cpp_pkg::ST_IDLE;
          nxt.idx  = 8'd0;
          nxt.xsum = 8'd0;
        end
        default: begin
          nxt.st = cpp_pkg::ST_IDLE;
        end
      endcase
      if (nxt.idx > IdxLimit) begin
        nxt.ovfs              = cur_i.ovfs + 16'd1;
        nxt.st                = cpp_pkg::ST_IDLE;
        nxt.idx               = 8'd0;
        nxt.xsum              = 8'd0;
        res_o.length_overflow = 1'b1;
        if (mode_is_zero_i) begin
          res_o.repaint_request = 1'b1;
        end
      end
    end
    res_o.byte_index = have_len ? len : nxt.idx;
    nxt_o            = nxt;
  end

endmodule

`default_nettype wire

### rtl/ctrl_packet_parser.sv
// Top level of the control packet parser: input register, parser state, result register.
// The parser takes one item per clock cycle while in_ready_o is high and gives one result
// item for each item taken. An item is captured in the input register, passes the parser
// logic and lands in the result register, from which its result is offered. The single
// parser state register is updated once per item; in_ready_o only drops while a finished
// result waits on out_ready_i and the input register is full.
// Configuration takes effect for the items that follow the write; cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ctrl_packet_parser #(
  parameter int MAX_INDEX = 198
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [0:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               line_changed_i,
  input  logic               hold_active_i,
  input  logic               display_active_i,
  input  logic               ui_busy_i,
  input  logic signed [15:0] defer_countdown_i,
  input  logic               mode_is_zero_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic [7:0]         byte_index_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         command_code_o,
  output logic               length_overflow_o,
  output logic               repaint_request_o,
  output logic [15:0]        packets_started_o,
  output logic [15:0]        deferrals_o,
  output logic [15:0]        checksum_errors_o,
  output logic [15:0]        length_errors_o
);

  logic                special_select_q;
  logic                flag_is_m_q;

  logic                s1_valid_q;
  logic                s1_adv;
  logic [7:0]          s1_byte_q;
  logic                s1_changed_q;
  logic                s1_hold_q;
  logic                s1_disp_q;
  logic                s1_busy_q;
  logic signed [15:0]  s1_cd_q;
  logic                s1_mode0_q;

  cpp_pkg::cpp_state_t state_q;
  cpp_pkg::cpp_state_t state_d;
  cpp_pkg::cpp_res_t   step_res;

  logic                out_valid_q;
  cpp_pkg::cpp_res_t   out_res_q;
  cpp_pkg::cpp_state_t out_st_q;

  logic                ovf_step;
  logic                start_step;
  logic                parser_clear;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_select_q <= 1'b0;
      flag_is_m_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cpp_pkg::CFG_SPECIAL_SELECT: special_select_q <= cfg_data_i[0];
        cpp_pkg::CFG_FLAG_IS_M:      flag_is_m_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // hold the item in the input register until the parser takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q    <= rx_byte_i;
      s1_changed_q <= line_changed_i;
      s1_hold_q    <= hold_active_i;
      s1_disp_q    <= display_active_i;
      s1_busy_q    <= ui_busy_i;
      s1_cd_q      <= defer_countdown_i;
      s1_mode0_q   <= mode_is_zero_i;
    end
  end

  cpp_step #(
    .MAX_INDEX (MAX_INDEX)
  ) u_step (
    .cur_i             (state_q),
    .special_select_i  (special_select_q),
    .flag_is_m_i       (flag_is_m_q),
    .rx_byte_i         (s1_byte_q),
    .line_changed_i    (s1_changed_q),
    .hold_active_i     (s1_hold_q),
    .display_active_i  (s1_disp_q),
    .ui_busy_i         (s1_busy_q),
    .defer_countdown_i (s1_cd_q),
    .mode_is_zero_i    (s1_mode0_q),
    .nxt_o             (state_d),
    .res_o             (step_res)
  );

  // advance the parser state once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{st: cpp_pkg::ST_IDLE, default: '0};
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= step_res;
      out_st_q  <= state_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = out_res_q.evt;
  assign byte_index_o      = out_res_q.byte_index;
  assign data_byte_o       = out_res_q.data_byte;
  assign length_overflow_o = out_res_q.length_overflow;
  assign repaint_request_o = out_res_q.repaint_request;
  assign command_code_o    = out_st_q.code;
  assign packets_started_o = out_st_q.started;
  assign deferrals_o       = out_st_q.defers;
  assign checksum_errors_o = out_st_q.xerrs;
  assign length_errors_o   = out_st_q.ovfs;

  assign ovf_step     = s1_adv & step_res.length_overflow;
  assign start_step   = s1_adv & (step_res.evt == cpp_pkg::EV_START);
  assign parser_clear = (state_q.idx == 8'd0) & (state_q.st == cpp_pkg::ST_IDLE);

  `CPP_ASSERT(a_ovf_clears, clk_i, rst_ni, ovf_step |=> parser_clear)
  `CPP_ASSERT_NEVER(a_idx_limit, clk_i, rst_ni, state_q.idx > 8'(MAX_INDEX))
  `CPP_ASSERT(a_start_count, clk_i, rst_ni, start_step |=> state_q.started == $past(state_q.started) + 16'd1)
  `CPP_ASSERT(a_stall_only, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule

`default_nettype wire
